/* src/mi3_pkg.sv */
// Shared types and constants for the 3x3 matrix inverse core.
`timescale 1ns / 1ps
`default_nettype none
package mi3_pkg;

  localparam int unsigned Dim   = 3;
  localparam int unsigned Lanes = Dim * Dim;
  localparam int unsigned InW   = 16;
  localparam int unsigned OutW  = 32;
  localparam int unsigned ProdW = 2 * InW;        // entry x entry
  localparam int unsigned CofW  = ProdW + 1;      // difference of two products
  localparam int unsigned PartW = InW + CofW;     // entry x cofactor
  localparam int unsigned DetW  = PartW + 2;      // sum of three partials
  localparam int unsigned MagW  = CofW - 1;       // cofactor magnitude
  localparam int unsigned DabsW = DetW - 2;       // determinant magnitude
  localparam int unsigned DenW  = DabsW + 1;      // 2 * |det|
  localparam int unsigned FracSh = 24;
  localparam int unsigned NumW  = MagW + FracSh + 2; // 2*|cof|*2^24 + |det|
  localparam int unsigned QuoW  = OutW + 1;       // quotient bits below overflow
  localparam int unsigned QCntW = 2;

  localparam logic [OutW-1:0] SatMax = {1'b0, {(OutW-1){1'b1}}};
  localparam logic [OutW-1:0] SatMin = {1'b1, {(OutW-1){1'b0}}};

  typedef struct packed {
    logic [Lanes-1:0][NumW-1:0] num;
    logic [Lanes-1:0]           neg;
    logic [DenW-1:0]            den;
    logic                       sing;
  } mi3_job_t;

  typedef struct packed {
    logic push;
    logic full;
  } mi3_qctl_t;

endpackage
`default_nettype wire

/* src/matrix_inverse_3x3_core.sv */
// Top level of the 3x3 matrix inverse core (adjugate over determinant).
//
//  channel  | direction | tdata                          | tuser
//  s_axis   | in        | m00..m22, 16 b Q8.8 each       | -
//  m_axis   | out       | m00..m22, 32 b Q16.16 each     | singular
//
// One matrix a cycle sustained without output stalls; data passes 4 front stages,
// the queue and 35 divider stages (overflow check, 33 quotient bits, saturation
// register). The rate is set by the bit-per-stage divider, nine lanes wide.
// Reset clears only valid bits, the queue pointers and the queue count.
// An output stall holds the divider; the front runs till the 2-entry queue fills.
`timescale 1ns / 1ps
`default_nettype none
module matrix_inverse_3x3_core (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  wire  [143:0] s_axis_tdata_i,  // m00,m01,m02,m10,m11,m12,m20,m21,m22
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  output logic [287:0] m_axis_tdata_o,  // m00,m01,m02,m10,m11,m12,m20,m21,m22
  output logic         m_axis_tuser_o   // singular
);

  mi3_pkg::mi3_qctl_t qctl;
  mi3_pkg::mi3_job_t  job, head;
  logic               push, pop, avail;

  mi3_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_data_i   (s_axis_tdata_i),
    .in_ready_o  (s_axis_tready_o),
    .qctl_i      (qctl),
    .job_valid_o (push),
    .job_o       (job)
  );

  mi3_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (job),
    .pop_i       (pop),
    .qctl_o      (qctl),
    .not_empty_o (avail),
    .head_o      (head)
  );

  mi3_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_avail_i (avail),
    .job_i       (head),
    .job_pop_o   (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_sing_o  (m_axis_tuser_o)
  );

endmodule
`default_nettype wire

/* src/mi3_front.sv */
// Front pipeline: register matrix, form cofactors and determinant, build divider job.
`timescale 1ns / 1ps
`default_nettype none
module mi3_front (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire                                       in_valid_i,
  input  wire  [mi3_pkg::Lanes*mi3_pkg::InW-1:0]    in_data_i,
  output logic                                      in_ready_o,
  input  wire  mi3_pkg::mi3_qctl_t                  qctl_i,
  output logic                                      job_valid_o,
  output mi3_pkg::mi3_job_t                         job_o
);

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q;
  logic signed [mi3_pkg::InW-1:0]   a_q   [mi3_pkg::Lanes];
  logic signed [mi3_pkg::ProdW-1:0] pa_q  [mi3_pkg::Lanes];
  logic signed [mi3_pkg::ProdW-1:0] pb_q  [mi3_pkg::Lanes];
  logic signed [mi3_pkg::InW-1:0]   r0a_q [mi3_pkg::Dim];
  logic signed [mi3_pkg::InW-1:0]   r0b_q [mi3_pkg::Dim];
  logic signed [mi3_pkg::CofW-1:0]  cof_q [mi3_pkg::Lanes];
  logic signed [mi3_pkg::CofW-1:0]  cof4_q[mi3_pkg::Lanes];
  logic signed [mi3_pkg::PartW-1:0] part_q[mi3_pkg::Dim];

  // The whole front moves together while the queue has room.
  assign adv        = !qctl_i.full;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < mi3_pkg::Lanes; i++) begin
        a_q[i] <= in_data_i[i*mi3_pkg::InW +: mi3_pkg::InW];
      end
      // adjugate terms, row-major, first minus second product
      pa_q[0] <= a_q[4] * a_q[8];  pb_q[0] <= a_q[5] * a_q[7];
      pa_q[1] <= a_q[2] * a_q[7];  pb_q[1] <= a_q[1] * a_q[8];
      pa_q[2] <= a_q[1] * a_q[5];  pb_q[2] <= a_q[2] * a_q[4];
      pa_q[3] <= a_q[5] * a_q[6];  pb_q[3] <= a_q[3] * a_q[8];
      pa_q[4] <= a_q[0] * a_q[8];  pb_q[4] <= a_q[2] * a_q[6];
      pa_q[5] <= a_q[2] * a_q[3];  pb_q[5] <= a_q[0] * a_q[5];
      pa_q[6] <= a_q[3] * a_q[7];  pb_q[6] <= a_q[4] * a_q[6];
      pa_q[7] <= a_q[1] * a_q[6];  pb_q[7] <= a_q[0] * a_q[7];
      pa_q[8] <= a_q[0] * a_q[4];  pb_q[8] <= a_q[1] * a_q[3];
      for (int i = 0; i < mi3_pkg::Dim; i++) begin
        r0a_q[i] <= a_q[i];
        r0b_q[i] <= r0a_q[i];
      end
      for (int i = 0; i < mi3_pkg::Lanes; i++) begin
        cof_q[i]  <= mi3_pkg::CofW'(pa_q[i]) - mi3_pkg::CofW'(pb_q[i]);
        cof4_q[i] <= cof_q[i];
      end
      // expand along row 0: det = sum a0c * adj[c][0]
      for (int i = 0; i < mi3_pkg::Dim; i++) begin
        part_q[i] <= r0b_q[i] * cof_q[i*mi3_pkg::Dim];
      end
    end
  end

  always_comb begin
    logic signed [mi3_pkg::DetW-1:0] det;
    logic        [mi3_pkg::DetW-1:0] dabs_w;
    logic        [mi3_pkg::DabsW-1:0] dabs;
    logic        [mi3_pkg::CofW-1:0] cabs_w;
    det = mi3_pkg::DetW'(part_q[0]) + mi3_pkg::DetW'(part_q[1])
        + mi3_pkg::DetW'(part_q[2]);
    dabs_w = det[mi3_pkg::DetW-1] ? mi3_pkg::DetW'(-det) : mi3_pkg::DetW'(det);
    dabs   = dabs_w[mi3_pkg::DabsW-1:0];
    job_o.den  = {dabs, 1'b0};
    job_o.sing = (det == '0);
    for (int i = 0; i < mi3_pkg::Lanes; i++) begin
      cabs_w = cof4_q[i][mi3_pkg::CofW-1] ? mi3_pkg::CofW'(-cof4_q[i])
                                           : mi3_pkg::CofW'(cof4_q[i]);
      // round half away: (2n + d) / (2d)
      job_o.num[i] = {1'b0, cabs_w[mi3_pkg::MagW-1:0], {(mi3_pkg::FracSh+1){1'b0}}}
                   + mi3_pkg::NumW'(dabs);
      job_o.neg[i] = cof4_q[i][mi3_pkg::CofW-1] ^ det[mi3_pkg::DetW-1];
    end
  end

  assign job_valid_o = v4_q && qctl_i.push;

endmodule
`default_nettype wire

/* src/mi3_queue.sv */
// Two-entry job queue between the front pipeline and the divider.
`timescale 1ns / 1ps
`default_nettype none
module mi3_queue (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       push_i,
  input  wire  mi3_pkg::mi3_job_t   push_data_i,
  input  wire                       pop_i,
  output mi3_pkg::mi3_qctl_t        qctl_o,
  output logic                      not_empty_o,
  output mi3_pkg::mi3_job_t         head_o
);

  mi3_pkg::mi3_job_t           mem_q [2];
  logic                        wr_ptr_q, rd_ptr_q;
  logic [mi3_pkg::QCntW-1:0]   cnt_q, cnt_d;
  logic                        full;

  assign full        = (cnt_q == mi3_pkg::QCntW'(2));
  assign not_empty_o = (cnt_q != '0);
  assign qctl_o.full = full;
  assign qctl_o.push = !full;
  assign head_o      = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

/* src/mi3_back.sv */
// Back end: pipelined restoring divider, one quotient bit per stage, and saturation.
`timescale 1ns / 1ps
`default_nettype none
module mi3_back (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  wire                                        job_avail_i,
  input  wire  mi3_pkg::mi3_job_t                    job_i,
  output logic                                       job_pop_o,
  output logic                                       out_valid_o,
  input  wire                                        out_ready_i,
  output logic [mi3_pkg::Lanes*mi3_pkg::OutW-1:0]    out_data_o,
  output logic                                       out_sing_o
);

  localparam int unsigned St = mi3_pkg::QuoW + 1;

  logic en;
  logic [St-1:0]                                     v_q;
  logic [mi3_pkg::NumW-1:0] rem_q [St][mi3_pkg::Lanes];
  logic [mi3_pkg::QuoW-1:0] quo_q [St][mi3_pkg::Lanes];
  logic [mi3_pkg::Lanes-1:0]  neg_q [St];
  logic [mi3_pkg::Lanes-1:0]  ovf_q [St];
  logic [mi3_pkg::DenW-1:0]   den_q [St];
  logic [St-1:0]              sing_q;
  logic                       out_valid_q;
  logic [mi3_pkg::Lanes*mi3_pkg::OutW-1:0] out_data_q;
  logic                       out_sing_q;

  // Stall the whole divider only while a finished result waits.
  assign en        = !out_valid_q || out_ready_i;
  assign job_pop_o = en && job_avail_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[St-2:0], job_avail_i};
      out_valid_q <= v_q[St-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < mi3_pkg::Lanes; l++) begin
        rem_q[0][l] <= job_i.num[l];
        quo_q[0][l] <= '0;
        ovf_q[0][l] <= (job_i.num[l] >> mi3_pkg::QuoW) >= mi3_pkg::NumW'(job_i.den);
      end
      neg_q[0]  <= job_i.neg;
      den_q[0]  <= job_i.den;
      sing_q[0] <= job_i.sing;
      for (int s = 0; s < St - 1; s++) begin
        for (int l = 0; l < mi3_pkg::Lanes; l++) begin
          if ((rem_q[s][l] >> (mi3_pkg::QuoW - 1 - s)) >= mi3_pkg::NumW'(den_q[s])) begin
            rem_q[s+1][l] <= rem_q[s][l]
                           - (mi3_pkg::NumW'(den_q[s]) << (mi3_pkg::QuoW - 1 - s));
            quo_q[s+1][l] <= quo_q[s][l]
                           | (mi3_pkg::QuoW'(1) << (mi3_pkg::QuoW - 1 - s));
          end else begin
            rem_q[s+1][l] <= rem_q[s][l];
            quo_q[s+1][l] <= quo_q[s][l];
          end
        end
        neg_q[s+1]  <= neg_q[s];
        ovf_q[s+1]  <= ovf_q[s];
        den_q[s+1]  <= den_q[s];
        sing_q[s+1] <= sing_q[s];
      end
      for (int l = 0; l < mi3_pkg::Lanes; l++) begin
        logic [mi3_pkg::QuoW-1:0] q;
        q = quo_q[St-1][l];
        if (sing_q[St-1]) begin
          out_data_q[l*mi3_pkg::OutW +: mi3_pkg::OutW] <= '0;
        end else if (neg_q[St-1][l]) begin
          if (ovf_q[St-1][l] || q > {1'b0, mi3_pkg::SatMin})
            out_data_q[l*mi3_pkg::OutW +: mi3_pkg::OutW] <= mi3_pkg::SatMin;
          else
            out_data_q[l*mi3_pkg::OutW +: mi3_pkg::OutW] <= ~q[mi3_pkg::OutW-1:0] + 1'b1;
        end else begin
          if (ovf_q[St-1][l] || q > {1'b0, mi3_pkg::SatMax})
            out_data_q[l*mi3_pkg::OutW +: mi3_pkg::OutW] <= mi3_pkg::SatMax;
          else
            out_data_q[l*mi3_pkg::OutW +: mi3_pkg::OutW] <= q[mi3_pkg::OutW-1:0];
        end
      end
      out_sing_q <= sing_q[St-1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_sing_o  = out_sing_q;

endmodule
`default_nettype wire

/* src/mi3_checker.sv */
// Port-level checks for the 3x3 matrix inverse core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mi3_checker (
  input wire         clk_i,
  input wire         rst_ni,
  input wire         s_axis_tvalid_i,
  input wire         s_axis_tready_o,
  input wire         m_axis_tvalid_o,
  input wire         m_axis_tready_i,
  input wire [287:0] m_axis_tdata_o,
  input wire         m_axis_tuser_o
);

  logic [6:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  // count requests in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {6'd0, in_acc} - {6'd0, out_acc};
    end
  end

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pend_q != '0) else $error("result without a request");

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("singular result with nonzero entries");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o)
    && $stable(m_axis_tuser_o)) else $error("output changed while stalled");

endmodule

bind matrix_inverse_3x3_core mi3_checker u_mi3_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
`default_nettype wire

/* verif/tb.sv */
// Testbench for the 3x3 matrix inverse core: directed and random matrices checked field by field.
`timescale 1ns / 1ps
module tb;

  typedef struct {
    logic [mi3_pkg::Lanes-1:0][mi3_pkg::OutW-1:0] ent;
    logic                                         sing;
  } inv_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [143:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [287:0] m_axis_tdata_o;
  logic         m_axis_tuser_o;

  matrix_inverse_3x3_core uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  inv_t        inv_q[$];
  int unsigned n_err = 0, n_sent = 0, n_got = 0, n_sing = 0, n_sat = 0;
  int unsigned cyc = 0;
  int unsigned src_idle = 0, snk_stall = 0;  // percent

  task automatic report(input string what, input int lane, input logic [31:0] got,
                        input logic [31:0] want);
    n_err++;
    $display("MISMATCH result %0d %s lane %0d got %h want %h", n_got, what, lane, got, want);
  endtask

  // round(cof * 2^24 / det), ties away from zero, saturated
  function automatic logic [mi3_pkg::OutW-1:0] scaled_quot(input longint cof,
                                                           input longint det);
    logic [127:0] n, d, q;
    logic         neg;
    neg = (cof < 0) != (det < 0);
    n = (cof < 0) ? 128'(-cof) : 128'(cof);
    d = (det < 0) ? 128'(-det) : 128'(det);
    q = ((n << 25) + d) / (2 * d);
    if (neg) return (q > 128'h8000_0000) ? mi3_pkg::SatMin : mi3_pkg::OutW'(-q);
    return (q > 128'h7FFF_FFFF) ? mi3_pkg::SatMax : mi3_pkg::OutW'(q);
  endfunction

  function automatic inv_t invert(input logic [143:0] m);
    longint a[3][3], adj[9], det;
    inv_t   r;
    for (int i = 0; i < 9; i++) a[i/3][i%3] = longint'($signed(m[i*16 +: 16]));
    det = a[0][0]*a[1][1]*a[2][2] + a[0][1]*a[1][2]*a[2][0] + a[0][2]*a[1][0]*a[2][1]
        - a[0][2]*a[1][1]*a[2][0] - a[0][0]*a[1][2]*a[2][1] - a[0][1]*a[1][0]*a[2][2];
    adj[0] = a[1][1]*a[2][2] - a[1][2]*a[2][1];
    adj[1] = a[0][2]*a[2][1] - a[0][1]*a[2][2];
    adj[2] = a[0][1]*a[1][2] - a[0][2]*a[1][1];
    adj[3] = a[1][2]*a[2][0] - a[1][0]*a[2][2];
    adj[4] = a[0][0]*a[2][2] - a[0][2]*a[2][0];
    adj[5] = a[0][2]*a[1][0] - a[0][0]*a[1][2];
    adj[6] = a[1][0]*a[2][1] - a[1][1]*a[2][0];
    adj[7] = a[0][1]*a[2][0] - a[0][0]*a[2][1];
    adj[8] = a[0][0]*a[1][1] - a[0][1]*a[1][0];
    r.sing = (det == 0);
    for (int i = 0; i < 9; i++) r.ent[i] = r.sing ? '0 : scaled_quot(adj[i], det);
    return r;
  endfunction

  // Send one matrix; valid stays high across back-to-back requests.
  task automatic send_matrix(input logic [143:0] m);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= m;
    do @(posedge clk_i); while (!s_axis_tready_o);
    inv_q.push_back(invert(m));
    n_sent++;
  endtask

  function automatic logic [143:0] pack9(input logic [15:0] e[9]);
    logic [143:0] m;
    for (int i = 0; i < 9; i++) m[i*16 +: 16] = e[i];
    return m;
  endfunction

  always @(posedge clk_i) begin
    cyc++;
    if (cyc > 2_000_000) begin
      $display("Regression FAIL");
      $finish;
    end
    m_axis_tready_i <= ($urandom_range(99) >= snk_stall);
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (inv_q.size() == 0) begin
        report("unexpected", -1, 32'(m_axis_tuser_o), 0);
      end else begin
        inv_t w;
        w = inv_q.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (m_axis_tdata_o[i*32 +: 32] !== w.ent[i])
            report("entry", i, m_axis_tdata_o[i*32 +: 32], w.ent[i]);
          if (w.ent[i] == mi3_pkg::SatMax || w.ent[i] == mi3_pkg::SatMin) n_sat++;
        end
        if (m_axis_tuser_o !== w.sing) report("singular", 9, 32'(m_axis_tuser_o), 32'(w.sing));
        if (w.sing) n_sing++;
      end
      n_got++;
    end
  end

  task automatic test_directed();
    logic [15:0] e[9];
    // identity, scaled identity, extremes, zero, rank-deficient
    e = '{16'h0100, 0, 0, 0, 16'h0100, 0, 0, 0, 16'h0100};
    send_matrix(pack9(e));
    e = '{16'h0001, 0, 0, 0, 16'h0001, 0, 0, 0, 16'h0001};  // tiny det, large entries in range
    send_matrix(pack9(e));
    e = '{16'hFFFF, 0, 0, 0, 16'h0001, 0, 0, 0, 16'h0001};  // negative entries, in range
    send_matrix(pack9(e));
    e = '{16'h7FFF, 0, 0, 0, 16'h7FFF, 0, 0, 0, 16'h7FFF};
    send_matrix(pack9(e));
    e = '{16'h8000, 0, 0, 0, 16'h8000, 0, 0, 0, 16'h8000};
    send_matrix(pack9(e));
    e = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
          16'h8000, 16'h7FFF, 16'h7FFF};
    send_matrix(pack9(e));
    e = '{default: 16'h0000};
    send_matrix(pack9(e));
    e = '{default: 16'hFFFF};
    send_matrix(pack9(e));
    e = '{default: 16'h8000};
    send_matrix(pack9(e));
    e = '{default: 16'h7FFF};
    send_matrix(pack9(e));
    e = '{16'h0100, 16'h0200, 16'h0300, 16'h0200, 16'h0400, 16'h0600,
          16'h0001, 16'h0005, 16'h0009};  // two dependent rows
    send_matrix(pack9(e));
    e = '{16'h0200, 0, 0, 0, 16'h0300, 0, 0, 0, 16'h0100};  // rounding on 1/3
    send_matrix(pack9(e));
    e = '{16'h0300, 0, 0, 0, 16'hFD00, 0, 0, 0, 16'h0700};
    send_matrix(pack9(e));
    e = '{16'h0000, 16'h0100, 0, 16'h0100, 0, 0, 0, 0, 16'hFF00};  // permutation
    send_matrix(pack9(e));
  endtask

  task automatic test_random(input int unsigned cnt);
    logic [15:0] e[9];
    int unsigned k;
    for (int n = 0; n < cnt; n++) begin
      k = $urandom_range(9);
      for (int i = 0; i < 9; i++)
        case (k) inside
          [0:2]:   e[i] = 16'($urandom);
          [3:4]:   e[i] = 16'($signed($urandom_range(2047)) - 1024);  // near unit scale
          5:       e[i] = 16'($signed($urandom_range(15)) - 8);       // tiny: saturation
          6:       e[i] = ($urandom_range(1)) ? 16'(16'h7FFF - $urandom_range(3))
                                              : 16'(16'h8000 + $urandom_range(3));
          default: e[i] = (i % 4 == 0) ? 16'($urandom) : 16'($urandom_range(3) * 256);
        endcase
      // drop a row into a copy of another to hit the singular path
      if ($urandom_range(9) == 0)
        for (int c = 0; c < 3; c++) e[6 + c] = e[c];
      send_matrix(pack9(e));
    end
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (inv_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(180);
    src_idle = 88;
    test_random(160);
    src_idle = 0;
    snk_stall = 88;
    test_random(160);
    src_idle = 25;
    snk_stall = 25;
    test_random(180);
    snk_stall = 0;
    src_idle = 0;
    drain();
    $display("Covered %0d matrices, %0d singular, %0d saturated entries.",
             n_got, n_sing, n_sat);
    $display("Flow phases: none, sender idle, receiver stall, both.");
    if (n_err == 0 && inv_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
